// ----- src/mrp_pkg.sv -----
package mrp_pkg;

    localparam int LENGTH_LIMIT_DEF = 4096;
    localparam int CFG_W            = 13;
    localparam logic [CFG_W-1:0] RULE_MAX_LENGTH_RST = 13'd256;

    // register indexes on the configuration port
    localparam logic [0:0] REG_RULE_MAX_LENGTH = 1'b0;

    // event kinds
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_CHAR  = 2'd1;
    localparam logic [1:0] EV_END   = 2'd2;
    localparam logic [1:0] EV_RULE  = 2'd3;

    // verdict codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_SYNTAX  = 3'd1;
    localparam logic [2:0] ERR_UNKNOWN = 3'd2;
    localparam logic [2:0] ERR_DUP     = 3'd3;
    localparam logic [2:0] ERR_LONG    = 3'd4;

    // field ids
    localparam logic [1:0] FLD_TYPE = 2'd0;

    typedef enum logic [6:0] {
        PH_START    = 7'b0000001,
        PH_KEY_WAIT = 7'b0000010,
        PH_KEY      = 7'b0000100,
        PH_QUOTE    = 7'b0001000,
        PH_VALUE    = 7'b0010000,
        PH_AFTER    = 7'b0100000,
        PH_ERROR    = 7'b1000000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  key_pos;
        logic [3:0]  key_cand;
        logic [1:0]  cur_field;
        logic [3:0]  seen;
        logic [2:0]  perr;
        logic [2:0]  tpos;
        logic        tok;
    } t_parse_state;

    typedef struct packed {
        logic        long_end;   // count already at limit when the terminator comes
        logic        long_now;   // this character brings the count to the limit
    } t_len_flags;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  field;
        logic [7:0]  vchar;
        logic        accepted;
        logic [2:0]  err;
        logic [3:0]  present;
        logic        admits;
    } t_result;

    localparam t_parse_state RULE_CLEAR = '{
        phase:     PH_START,
        key_pos:   4'd0,
        key_cand:  4'hF,
        cur_field: 2'd0,
        seen:      4'd0,
        perr:      ERR_NONE,
        tpos:      3'd0,
        tok:       1'b1
    };

    localparam logic [7:0] KEY_WORDS [0:3][0:8] = '{
        '{"t", "y", "p", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "n", "t", "e", "r",   "f",   "a",   "c",   "e"},
        '{"m", "e", "m", "b", "e",   "r",   8'h00, 8'h00, 8'h00},
        '{"p", "a", "t", "h", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] KEY_LENS [0:3] = '{4'd4, 4'd9, 4'd6, 4'd4};
    localparam logic [7:0] SIGNAL_WORD [0:5] = '{"s", "i", "g", "n", "a", "l"};
    localparam logic [2:0] SIGNAL_LEN = 3'd6;

    function automatic logic is_key_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || c == 8'h09;
    endfunction

    function automatic logic key_hit(input logic [1:0] k, input logic [3:0] pos,
                                     input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        if (pos < KEY_LENS[k]) begin
            hit = (KEY_WORDS[k][pos] == c);
        end
        return hit;
    endfunction

    function automatic logic signal_hit(input logic [2:0] pos, input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        if (pos < SIGNAL_LEN) begin
            hit = (SIGNAL_WORD[pos] == c);
        end
        return hit;
    endfunction

endpackage

// ----- src/mrp_step.sv -----
module mrp_step (
    input  mrp_pkg::t_parse_state i_state,
    input  logic [7:0]            i_ch,
    input  mrp_pkg::t_len_flags   i_flags,
    output mrp_pkg::t_parse_state o_state,
    output mrp_pkg::t_result      o_result
);

    // narrow the key candidate set by one character
    function automatic logic [3:0] cand_step(input logic [3:0] cand, input logic [3:0] pos,
                                             input logic [7:0] c);
        logic [3:0] res;
        res = cand;
        for (int i = 0; i < 4; i++) begin
            if (!mrp_pkg::key_hit(2'(i), pos, c)) begin
                res[i] = 1'b0;
            end
        end
        return res;
    endfunction

    logic [3:0]   pos_inc;
    logic [3:0]   found_mask;
    logic         found_any;
    logic [1:0]   found_id;

    assign pos_inc = (i_state.key_pos < 4'd15) ? i_state.key_pos + 4'd1 : i_state.key_pos;

    // key complete: candidate whose length equals the characters seen
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            found_mask[i] = i_state.key_cand[i] && (mrp_pkg::KEY_LENS[i] == i_state.key_pos);
        end
        found_any = |found_mask;
        found_id  = 2'd0;
        priority if (found_mask[3]) found_id = 2'd3;
        else if (found_mask[2])     found_id = 2'd2;
        else if (found_mask[1])     found_id = 2'd1;
        else                        found_id = 2'd0;
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_ch == 8'h00) begin
            o_result.kind = mrp_pkg::EV_RULE;
            priority if (i_flags.long_end) begin
                o_result.err = mrp_pkg::ERR_LONG;
            end else if (i_state.phase == mrp_pkg::PH_START ||
                         i_state.phase == mrp_pkg::PH_AFTER) begin
                o_result.err = mrp_pkg::ERR_NONE;
            end else if (i_state.phase == mrp_pkg::PH_ERROR) begin
                o_result.err = (i_state.perr != mrp_pkg::ERR_NONE) ? i_state.perr
                                                                  : mrp_pkg::ERR_SYNTAX;
            end else begin
                o_result.err = mrp_pkg::ERR_SYNTAX;
            end
            if (o_result.err == mrp_pkg::ERR_NONE) begin
                o_result.accepted = 1'b1;
                o_result.present  = i_state.seen;
                o_result.admits   = !i_state.seen[mrp_pkg::FLD_TYPE] ||
                                    (i_state.tok && i_state.tpos == mrp_pkg::SIGNAL_LEN);
            end
            o_state = mrp_pkg::RULE_CLEAR;
        end else if (i_flags.long_now) begin
            o_state.perr  = mrp_pkg::ERR_LONG;
            o_state.phase = mrp_pkg::PH_ERROR;
        end else begin
            unique case (i_state.phase)
                mrp_pkg::PH_START, mrp_pkg::PH_KEY_WAIT: begin
                    if (mrp_pkg::is_blank(i_ch)) begin
                        o_state.phase = mrp_pkg::PH_KEY_WAIT;
                    end else if (mrp_pkg::is_key_char(i_ch)) begin
                        o_state.key_cand = cand_step(4'hF, 4'd0, i_ch);
                        o_state.key_pos  = 4'd1;
                        o_state.phase    = mrp_pkg::PH_KEY;
                    end else begin
                        o_state.perr  = mrp_pkg::ERR_SYNTAX;
                        o_state.phase = mrp_pkg::PH_ERROR;
                    end
                end
                mrp_pkg::PH_KEY: begin
                    if (mrp_pkg::is_key_char(i_ch)) begin
                        o_state.key_cand = cand_step(i_state.key_cand, i_state.key_pos, i_ch);
                        o_state.key_pos  = pos_inc;
                    end else if (i_ch == "=") begin
                        if (!found_any) begin
                            o_state.perr = mrp_pkg::ERR_UNKNOWN;
                        end else if (i_state.seen[found_id]) begin
                            o_state.perr = mrp_pkg::ERR_DUP;
                        end else begin
                            o_state.perr      = mrp_pkg::ERR_NONE;
                            o_state.cur_field = found_id;
                            if (found_id == mrp_pkg::FLD_TYPE) begin
                                o_state.tpos = 3'd0;
                                o_state.tok  = 1'b1;
                            end
                        end
                        o_state.phase = mrp_pkg::PH_QUOTE;
                    end else begin
                        o_state.perr  = mrp_pkg::ERR_SYNTAX;
                        o_state.phase = mrp_pkg::PH_ERROR;
                    end
                end
                mrp_pkg::PH_QUOTE: begin
                    if (i_ch == "'") begin
                        o_state.phase = mrp_pkg::PH_VALUE;
                    end else begin
                        o_state.perr  = mrp_pkg::ERR_SYNTAX;
                        o_state.phase = mrp_pkg::PH_ERROR;
                    end
                end
                mrp_pkg::PH_VALUE: begin
                    if (i_ch == "'") begin
                        if (i_state.perr != mrp_pkg::ERR_NONE) begin
                            o_state.phase = mrp_pkg::PH_ERROR;
                        end else begin
                            o_state.seen[i_state.cur_field] = 1'b1;
                            o_result.kind  = mrp_pkg::EV_END;
                            o_result.field = i_state.cur_field;
                            o_state.phase  = mrp_pkg::PH_AFTER;
                        end
                    end else if (i_state.perr == mrp_pkg::ERR_NONE) begin
                        o_result.kind  = mrp_pkg::EV_CHAR;
                        o_result.field = i_state.cur_field;
                        o_result.vchar = i_ch;
                        if (i_state.cur_field == mrp_pkg::FLD_TYPE) begin
                            if (!mrp_pkg::signal_hit(i_state.tpos, i_ch)) begin
                                o_state.tok = 1'b0;
                            end
                            if (i_state.tpos < 3'd7) begin
                                o_state.tpos = i_state.tpos + 3'd1;
                            end
                        end
                    end
                end
                mrp_pkg::PH_AFTER: begin
                    if (mrp_pkg::is_blank(i_ch) || i_ch == ",") begin
                        o_state.phase = mrp_pkg::PH_AFTER;
                    end else if (mrp_pkg::is_key_char(i_ch)) begin
                        o_state.key_cand = cand_step(4'hF, 4'd0, i_ch);
                        o_state.key_pos  = 4'd1;
                        o_state.phase    = mrp_pkg::PH_KEY;
                    end else begin
                        o_state.perr  = mrp_pkg::ERR_SYNTAX;
                        o_state.phase = mrp_pkg::PH_ERROR;
                    end
                end
                mrp_pkg::PH_ERROR: begin
                    o_state.phase = mrp_pkg::PH_ERROR;
                end
                default: begin
                    o_state.phase = mrp_pkg::PH_ERROR;
                end
            endcase
        end
    end

endmodule

// ----- src/match_rule_parser.sv -----
// match rule parser: takes a rule one character byte per input beat (code 0 ends
// the rule) and gives exactly one result beat per character: nothing, a value
// character tagged with its field, a value-ended mark, or the rule verdict with
// error code, fields present and whether the type admits signals. one character
// is taken per cycle unless a waiting result is held back by the consumer; the
// parser decision is combinational logic between the accepted character and the
// result register, and the input side stays ready while a result waits as long
// as the consumer takes that result in the same cycle. rule_max_length (reset 256)
// is written over the apb port at address 0; its effect is capped at LENGTH_LIMIT.
module match_rule_parser #(
    parameter int LENGTH_LIMIT = mrp_pkg::LENGTH_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_ch,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_event_kind,
    output logic [1:0]  o_field_id,
    output logic [7:0]  o_value_char,
    output logic        o_rule_accepted,
    output logic [2:0]  o_error_code,
    output logic [3:0]  o_fields_present,
    output logic        o_type_admits_signal,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // count width holds LENGTH_LIMIT itself, compare width covers the register too
    localparam int CW = $clog2(LENGTH_LIMIT + 1);
    localparam int LW = (CW > mrp_pkg::CFG_W) ? CW : mrp_pkg::CFG_W;

    logic [mrp_pkg::CFG_W-1:0] r_max_len;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    mrp_pkg::t_parse_state     r_state;
    mrp_pkg::t_parse_state     n_state;
    mrp_pkg::t_result          n_result;
    mrp_pkg::t_result          r_result;
    mrp_pkg::t_len_flags       len_flags;
    logic                      r_out_valid;
    logic                      in_beat;
    logic                      cfg_wr;
    logic [LW-1:0]             max_ext;
    logic [LW-1:0]             limit;
    logic [CW-1:0]             count_inc;

    // ---------------------------------------------------------------------
    // configuration register
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr == {mrp_pkg::REG_RULE_MAX_LENGTH, 2'b00});
    assign prdata = (paddr == {mrp_pkg::REG_RULE_MAX_LENGTH, 2'b00}) ?
                    {{(32 - mrp_pkg::CFG_W){1'b0}}, r_max_len} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= mrp_pkg::RULE_MAX_LENGTH_RST;
        end else if (cfg_wr) begin
            r_max_len <= pwdata[mrp_pkg::CFG_W-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // length limit: effective limit is the smaller of register and parameter
    // ---------------------------------------------------------------------
    assign max_ext   = LW'(r_max_len);
    assign limit     = (max_ext < LW'(LENGTH_LIMIT)) ? max_ext : LW'(LENGTH_LIMIT);
    // count saturates at LENGTH_LIMIT
    assign count_inc = (r_count < CW'(LENGTH_LIMIT)) ? r_count + CW'(1) : r_count;

    assign len_flags.long_end = (LW'(r_count) >= limit);
    assign len_flags.long_now = (LW'(count_inc) >= limit);

    // ---------------------------------------------------------------------
    // handshake: result register frees up when the consumer takes its beat
    // ---------------------------------------------------------------------
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_beat    = i_in_valid && o_in_ready;

    // per-character parser decision
    mrp_step u_step (
        .i_state  (r_state),
        .i_ch     (i_ch),
        .i_flags  (len_flags),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // terminator clears the count for the next rule
    assign n_count = (i_ch == 8'h00) ? '0 : count_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mrp_pkg::RULE_CLEAR;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_state <= n_state;
                r_count <= n_count;
            end
            if (in_beat) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with every accepted character
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_event_kind         = r_result.kind;
    assign o_field_id           = r_result.field;
    assign o_value_char         = r_result.vchar;
    assign o_rule_accepted      = r_result.accepted;
    assign o_error_code         = r_result.err;
    assign o_fields_present     = r_result.present;
    assign o_type_admits_signal = r_result.admits;

endmodule

// ----- bench/parse_checker.sv -----
module parse_checker
    import mrp_pkg::*;
#(
    parameter int LENGTH_LIMIT = LENGTH_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character channel
    input  logic        i_ch_valid,
    input  logic        i_ch_ready,
    input  logic [7:0]  i_ch,
    // result channel
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [1:0]  i_res_kind,
    input  logic [1:0]  i_res_field,
    input  logic [7:0]  i_res_char,
    input  logic        i_res_accepted,
    input  logic [2:0]  i_res_error,
    input  logic [3:0]  i_res_present,
    input  logic        i_res_admits,
    // configuration port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_waiting
);

    // parser state as the block should hold it
    t_phase           phase;
    logic [3:0]       key_pos;
    logic [3:0]       key_cand;
    logic [1:0]       cur_field;
    logic [3:0]       seen;
    logic [2:0]       pend_err;
    logic [2:0]       sig_pos;
    logic             sig_ok;
    int               char_cnt;
    logic [CFG_W-1:0] max_len;

    t_result expected_events[$];
    int      fails = 0;

    initial begin
        o_fail_count = 0;
        o_waiting    = 0;
    end

    function automatic string key_word(input int k);
        case (k)
            0:       return "type";
            1:       return "interface";
            2:       return "member";
            default: return "path";
        endcase
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic void start_rule();
        phase     = PH_START;
        key_pos   = '0;
        key_cand  = 4'hF;
        cur_field = '0;
        seen      = '0;
        char_cnt  = 0;
        pend_err  = ERR_NONE;
        sig_pos   = '0;
        sig_ok    = 1'b1;
    endfunction

    function automatic void fail_syntax();
        pend_err = ERR_SYNTAX;
        phase    = PH_ERROR;
    endfunction

    // drop every key that does not have c at the current position
    function automatic void narrow_keys(input logic [7:0] c);
        string w;
        int    k;
        for (k = 0; k < 4; k++) begin
            w = key_word(k);
            if (key_cand[k] && (key_pos >= w.len() || w[key_pos] != c)) begin
                key_cand[k] = 1'b0;
            end
        end
        if (key_pos != 4'd15) begin
            key_pos++;
        end
    endfunction

    function automatic void open_key(input logic [7:0] c);
        key_cand = 4'hF;
        key_pos  = '0;
        narrow_keys(c);
        phase = PH_KEY;
    endfunction

    function automatic t_result predict_event(input logic [7:0] c);
        t_result r;
        string   w;
        string   sig_text;
        int      lim;
        int      found;
        int      k;
        r = '0;
        sig_text = "signal";
        lim = (int'(max_len) < LENGTH_LIMIT) ? int'(max_len) : LENGTH_LIMIT;

        // terminator: verdict, then back to a fresh rule
        if (c == 8'h00) begin
            r.kind = EV_RULE;
            if (char_cnt >= lim) begin
                r.err = ERR_LONG;
            end else if (phase == PH_START || phase == PH_AFTER) begin
                r.err = ERR_NONE;
            end else if (phase == PH_ERROR) begin
                r.err = (pend_err != ERR_NONE) ? pend_err : ERR_SYNTAX;
            end else begin
                r.err = ERR_SYNTAX;
            end
            if (r.err == ERR_NONE) begin
                r.accepted = 1'b1;
                r.present  = seen;
                r.admits   = !seen[FLD_TYPE] || (sig_ok && sig_pos == 3'd6);
            end
            start_rule();
            return r;
        end

        if (char_cnt < LENGTH_LIMIT) begin
            char_cnt++;
        end
        if (char_cnt >= lim) begin
            pend_err = ERR_LONG;
            phase    = PH_ERROR;
            return r;
        end

        case (phase)
            PH_START, PH_KEY_WAIT: begin
                if (c == " " || c == 8'h09) begin
                    phase = PH_KEY_WAIT;
                end else if (is_name_char(c)) begin
                    open_key(c);
                end else begin
                    fail_syntax();
                end
            end
            PH_KEY: begin
                if (is_name_char(c)) begin
                    narrow_keys(c);
                end else if (c == "=") begin
                    found = 4;
                    for (k = 0; k < 4; k++) begin
                        w = key_word(k);
                        if (key_cand[k] && key_pos == w.len()) begin
                            found = k;
                        end
                    end
                    if (found == 4) begin
                        pend_err = ERR_UNKNOWN;
                    end else if (seen[found]) begin
                        pend_err = ERR_DUP;
                    end else begin
                        pend_err  = ERR_NONE;
                        cur_field = 2'(found);
                        if (cur_field == FLD_TYPE) begin
                            sig_pos = '0;
                            sig_ok  = 1'b1;
                        end
                    end
                    phase = PH_QUOTE;
                end else begin
                    fail_syntax();
                end
            end
            PH_QUOTE: begin
                if (c == "'") begin
                    phase = PH_VALUE;
                end else begin
                    fail_syntax();
                end
            end
            PH_VALUE: begin
                if (c == "'") begin
                    // a held key error surfaces at the closing quote
                    if (pend_err != ERR_NONE) begin
                        phase = PH_ERROR;
                    end else begin
                        seen[cur_field] = 1'b1;
                        r.kind  = EV_END;
                        r.field = cur_field;
                        phase   = PH_AFTER;
                    end
                end else if (pend_err == ERR_NONE) begin
                    r.kind  = EV_CHAR;
                    r.field = cur_field;
                    r.vchar = c;
                    if (cur_field == FLD_TYPE) begin
                        if (sig_pos >= 3'd6 || sig_text[sig_pos] != c) begin
                            sig_ok = 1'b0;
                        end
                        if (sig_pos != 3'd7) begin
                            sig_pos++;
                        end
                    end
                end
            end
            PH_AFTER: begin
                if (c == " " || c == 8'h09 || c == ",") begin
                    phase = PH_AFTER;
                end else if (is_name_char(c)) begin
                    open_key(c);
                end else begin
                    fail_syntax();
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            start_rule();
            max_len = RULE_MAX_LENGTH_RST;
            expected_events.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr == 3'(4 * REG_RULE_MAX_LENGTH)) begin
                max_len = i_pwdata[CFG_W-1:0];
            end
            if (i_ch_valid && i_ch_ready) begin
                expected_events.push_back(predict_event(i_ch));
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_events.size() == 0) begin
                    $error("result beat with nothing expected, kind %0d", i_res_kind);
                    fails++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_kind", 8'(want.kind), 8'(i_res_kind));
                    check_field("field_id", 8'(want.field), 8'(i_res_field));
                    check_field("value_char", want.vchar, i_res_char);
                    check_field("rule_accepted", 8'(want.accepted), 8'(i_res_accepted));
                    check_field("error_code", 8'(want.err), 8'(i_res_error));
                    check_field("fields_present", 8'(want.present), 8'(i_res_present));
                    check_field("type_admits_signal", 8'(want.admits), 8'(i_res_admits));
                end
            end
        end
        o_waiting    <= expected_events.size();
        o_fail_count <= fails;
    end

endmodule

// ----- bench/testbench.sv -----
module testbench;

    // clock, reset and block ports; every input starts at a known value
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_ch            = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready     = 1'b0;
    logic [1:0]  o_event_kind;
    logic [1:0]  o_field_id;
    logic [7:0]  o_value_char;
    logic        o_rule_accepted;
    logic [2:0]  o_error_code;
    logic [3:0]  o_fields_present;
    logic        o_type_admits_signal;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [2:0]  paddr           = 3'd0;
    logic [31:0] pwdata          = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // from the checker
    int fail_count;
    int waiting;

    // idling: percent of cycles the sender holds back / the receiver stalls
    int idle_pct  = 0;
    int stall_pct = 0;
    int chars_sent = 0;

    // the rule being sent, without its terminator
    logic [7:0] rule_buf[$];

    match_rule_parser u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_ch                (i_ch),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_event_kind        (o_event_kind),
        .o_field_id          (o_field_id),
        .o_value_char        (o_value_char),
        .o_rule_accepted     (o_rule_accepted),
        .o_error_code        (o_error_code),
        .o_fields_present    (o_fields_present),
        .o_type_admits_signal(o_type_admits_signal),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    // watches both channels and the config port, predicts and compares
    parse_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ch_valid    (i_in_valid),
        .i_ch_ready    (o_in_ready),
        .i_ch          (i_ch),
        .i_res_valid   (o_out_valid),
        .i_res_ready   (i_out_ready),
        .i_res_kind    (o_event_kind),
        .i_res_field   (o_field_id),
        .i_res_char    (o_value_char),
        .i_res_accepted(o_rule_accepted),
        .i_res_error   (o_error_code),
        .i_res_present (o_fields_present),
        .i_res_admits  (o_type_admits_signal),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_fail_count  (fail_count),
        .o_waiting     (waiting)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stalls at the rate the current phase asks for
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // hard stop in case the block hangs a handshake
    initial begin
        #3_000_000;
        $display("match_rule_parser: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------- rule text

    function automatic string key_text(input int k);
        case (k)
            0:       return "type";
            1:       return "interface";
            2:       return "member";
            default: return "path";
        endcase
    endfunction

    function automatic void put_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) begin
            rule_buf.push_back(s[k]);
        end
    endfunction

    // value byte: mostly printable, now and then any byte but quote and terminator
    function automatic logic [7:0] value_byte();
        logic [7:0] c;
        do begin
            if ($urandom_range(3) == 0) begin
                c = 8'($urandom_range(1, 255));
            end else begin
                c = 8'($urandom_range(32, 126));
            end
        end while (c == "'");
        return c;
    endfunction

    function automatic logic [7:0] letter();
        case ($urandom_range(4))
            0:       return 8'($urandom_range("A", "Z"));
            1:       return "_";
            default: return 8'($urandom_range("a", "z"));
        endcase
    endfunction

    // run of blanks, tabs and commas as allowed after a closing quote
    function automatic void put_separators(input int most);
        int n;
        int k;
        n = $urandom_range(most);
        for (k = 0; k < n; k++) begin
            case ($urandom_range(2))
                0:       rule_buf.push_back(" ");
                1:       rule_buf.push_back(8'h09);
                default: rule_buf.push_back(",");
            endcase
        end
    endfunction

    // a key that looks close to a real one but is not (or, rarely, happens to be)
    function automatic void put_odd_key();
        string w;
        int    how;
        int    n;
        int    k;
        w   = key_text($urandom_range(3));
        how = $urandom_range(3);
        if (how == 3) begin
            n = $urandom_range(1, 10);
            for (k = 0; k < n; k++) begin
                rule_buf.push_back(letter());
            end
        end else begin
            // cut one letter off, add a trailing underscore, or capitalize
            n = (how == 0) ? w.len() - 1 : w.len();
            for (k = 0; k < n; k++) begin
                rule_buf.push_back((how == 2 && k == 0) ? w[k] - 8'd32 : w[k]);
            end
            if (how == 1) begin
                rule_buf.push_back("_");
            end
        end
    endfunction

    function automatic void put_value(input int fld);
        int n;
        int k;
        if (fld == 0 && $urandom_range(1) == 0) begin
            // type values right at and around "signal"
            case ($urandom_range(4))
                0, 1:    put_text("signal");
                2:       put_text("signa");
                3:       put_text("signals");
                default: put_text("method_call");
            endcase
        end else begin
            n = $urandom_range(8);
            for (k = 0; k < n; k++) begin
                rule_buf.push_back(value_byte());
            end
        end
    endfunction

    // well-formed rule with random content: mostly fresh keys, now and then a
    // duplicate or an unknown key
    function automatic void build_good_rule();
        logic [3:0] used;
        int         n;
        int         e;
        int         pick;
        int         fld;
        int         k;
        rule_buf.delete();
        used = '0;
        if ($urandom_range(3) == 0) begin
            n = $urandom_range(1, 2);
            for (k = 0; k < n; k++) begin
                rule_buf.push_back($urandom_range(1) ? 8'h20 : 8'h09);
            end
        end
        n = $urandom_range(4);
        for (e = 0; e < n; e++) begin
            if (e > 0) begin
                put_separators(3);
            end
            pick = $urandom_range(19);
            if (pick == 0) begin
                put_odd_key();
                fld = 1;
            end else begin
                if (pick == 1 && used != 4'h0) begin
                    do fld = $urandom_range(3); while (!used[fld]);
                end else if (used != 4'hF) begin
                    do fld = $urandom_range(3); while (used[fld]);
                end else begin
                    fld = $urandom_range(3);
                end
                used[fld] = 1'b1;
                put_text(key_text(fld));
            end
            put_text("='");
            put_value(fld);
            put_text("'");
        end
        if ($urandom_range(3) == 0) begin
            put_separators(2);
        end
    endfunction

    // well-formed rule with one fault: a byte replaced, a byte inserted, or cut short
    function automatic void build_broken_rule();
        int at;
        int cut;
        logic [7:0] c;
        build_good_rule();
        if (rule_buf.size() == 0) begin
            rule_buf.push_back(8'($urandom_range(1, 255)));
        end
        at = $urandom_range(rule_buf.size() - 1);
        case ($urandom_range(4))
            0:       c = "=";
            1:       c = "'";
            2:       c = ",";
            3:       c = " ";
            default: c = 8'($urandom_range(1, 255));
        endcase
        case ($urandom_range(2))
            0: rule_buf[at] = c;
            1: rule_buf.insert(at, c);
            default: begin
                cut = $urandom_range(rule_buf.size() - 1);
                while (rule_buf.size() > cut) begin
                    void'(rule_buf.pop_back());
                end
            end
        endcase
    endfunction

    function automatic void build_noise_rule();
        int n;
        int k;
        rule_buf.delete();
        n = $urandom_range(1, 12);
        for (k = 0; k < n; k++) begin
            case ($urandom_range(5))
                0:       rule_buf.push_back("=");
                1:       rule_buf.push_back("'");
                2:       rule_buf.push_back(",");
                3:       rule_buf.push_back(letter());
                default: rule_buf.push_back(8'($urandom_range(1, 255)));
            endcase
        end
    endfunction

    function automatic void build_random_rule();
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            build_good_rule();
        end else if (r < 85) begin
            build_broken_rule();
        end else begin
            build_noise_rule();
        end
    endfunction

    // ---------------------------------------------------------------- driving

    // one character beat; valid is only lowered when the sender idles, so a
    // back-to-back beat never sees valid dropped and raised in one step
    task automatic send_char(input logic [7:0] c);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch       <= c;
        do @(posedge i_clk); while (!o_in_ready);
        chars_sent++;
    endtask

    // sender goes quiet until every expected result beat has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (waiting != 0);
    endtask

    task automatic send_rule(input bit drain_mid);
        int k;
        for (k = 0; k < rule_buf.size(); k++) begin
            if (drain_mid && k == rule_buf.size() / 2) begin
                wait_drained();
            end
            send_char(rule_buf[k]);
        end
        send_char(8'h00);
    endtask

    task automatic send_text(input string s);
        rule_buf.delete();
        put_text(s);
        send_rule(1'b0);
    endtask

    // config write only with the parser idle: drain, let the last result settle,
    // then setup and access cycles; upper data bits are noise the block must drop
    task automatic set_limit(input logic [mrp_pkg::CFG_W-1:0] v);
        wait_drained();
        repeat (3) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * mrp_pkg::REG_RULE_MAX_LENGTH);
        pwdata  <= ($urandom() & 32'hFFFF_E000) | 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // random rules under one limit until about budget characters have gone in;
    // with mix_idling each rule picks its own idling pattern
    task automatic run_phase(input logic [mrp_pkg::CFG_W-1:0] v, input int idle,
                             input int stall, input bit mix_idling, input int budget);
        int stop;
        set_limit(v);
        idle_pct  = idle;
        stall_pct = stall;
        stop = chars_sent + budget;
        while (chars_sent < stop) begin
            if (mix_idling) begin
                case ($urandom_range(3))
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 66; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 66; end
                    default: begin idle_pct = 24; stall_pct = 24; end
                endcase
            end
            build_random_rule();
            send_rule($urandom_range(15) == 0);
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset limit of 256, no idling
        send_text("");                  // empty rule is accepted with no fields
        send_text(" \t");               // blanks only
        send_text(",");                 // comma ahead of the first key
        send_text("type='signal'");     // type that admits signals
        send_text("x='a'");             // unknown key, value swallowed
        // duplicate key, value bytes at both ends of the range
        rule_buf.delete();
        put_text("path='");
        rule_buf.push_back(8'hFF);
        rule_buf.push_back(8'h01);
        put_text("',path=''");
        send_rule(1'b0);
        // a zero limit rejects even the empty rule
        set_limit('0);
        send_text("");
        // a limit of one: the first character already hits it
        set_limit(13'd1);
        send_text("a");
        send_text("");

        // random phases, each under its own limit and idling pattern
        run_phase(13'd1, 0, 0, 1'b0, 60);
        run_phase(13'd0, 0, 0, 1'b0, 40);
        run_phase(13'd4096, 66, 0, 1'b0, 160);
        run_phase(13'h1FFF, 0, 66, 1'b0, 160);

        // one rule well past the reset limit: the rest is dropped, verdict is too long
        set_limit(13'd256);
        rule_buf.delete();
        put_text("path='");
        repeat (280) rule_buf.push_back(value_byte());
        put_text("'");
        send_rule(1'b0);

        run_phase(13'($urandom_range(5, 40)), 24, 24, 1'b0, 160);
        run_phase(13'd256, 0, 0, 1'b1, 140);

        // let everything come back, then a little tail for stray beats
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("match_rule_parser: match");
        end else begin
            $display("match_rule_parser: mismatch");
        end
        $finish;
    end

endmodule
